### rtl/ptst_pkg.sv
// Shared types and codes for the periodic timer slot table.
`default_nettype none
package ptst_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int RESULT_CAP = 8;

   localparam logic [4:0] SLOT_LIMIT = 5'(SLOT_COUNT);
   localparam logic [3:0] FIRE_CAP   = 4'(RESULT_CAP);

   // operation codes
   localparam logic [2:0] FUNC_REG_PERIODIC = 3'd0;
   localparam logic [2:0] FUNC_REG_ONE_SHOT = 3'd1;
   localparam logic [2:0] FUNC_RUN          = 3'd2;
   localparam logic [2:0] FUNC_ENABLE       = 3'd3;
   localparam logic [2:0] FUNC_DISABLE      = 3'd4;
   localparam logic [2:0] FUNC_DELETE       = 3'd5;

   // result status codes
   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_FULL    = 3'd1;
   localparam logic [2:0] STATUS_FIRED   = 3'd2;
   localparam logic [2:0] STATUS_NONE    = 3'd3;
   localparam logic [2:0] STATUS_IGNORED = 3'd4;

   // command token walking down the cell chain
   typedef struct packed {
      logic        valid;
      logic [2:0]  func;
      logic [31:0] now;
      logic [31:0] period;
      logic [15:0] tag;
      logic [3:0]  slot;
      logic        claimed;
      logic [3:0]  fired;
   } token_type;

   // result raised by the cell that holds the token
   typedef struct packed {
      logic        valid;
      logic [2:0]  status;
      logic [3:0]  index;
      logic [15:0] tag;
   } hit_type;

endpackage
`default_nettype wire

### rtl/ptst_cell.sv
// One timer slot: holds its state and acts on the token passing through.
`default_nettype none
module ptst_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [3:0]        cell_index,
   input  wire ptst_pkg::token_type tok_in,
   output ptst_pkg::token_type    tok_out,
   output ptst_pkg::hit_type      hit
);
   import ptst_pkg::*;

   logic        taken_ff, taken_in;
   logic        enabled_ff, enabled_in;
   logic        one_shot_ff, one_shot_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] tag_ff, tag_in;
   token_type   tok_ff, tok_in_next;
   logic [31:0] elapsed;
   logic        mine;

   assign elapsed = tok_in.now - start_ff;
   assign mine    = (tok_in.slot == cell_index);

   always_comb begin
      taken_in    = taken_ff;
      enabled_in  = enabled_ff;
      one_shot_in = one_shot_ff;
      period_in   = period_ff;
      start_in    = start_ff;
      tag_in      = tag_ff;
      tok_in_next = tok_in;
      hit         = '0;
      if (tok_in.valid) begin
         unique case (tok_in.func)
            FUNC_REG_PERIODIC, FUNC_REG_ONE_SHOT: begin
               // first free slot along the chain claims the registration
               if (!tok_in.claimed && !taken_ff && !enabled_ff) begin
                  taken_in            = 1'b1;
                  enabled_in          = 1'b1;
                  one_shot_in         = (tok_in.func == FUNC_REG_ONE_SHOT);
                  period_in           = tok_in.period;
                  start_in            = tok_in.now;
                  tag_in              = tok_in.tag;
                  tok_in_next.claimed = 1'b1;
                  hit.valid           = 1'b1;
                  hit.status          = STATUS_OK;
                  hit.index           = cell_index;
               end
            end
            FUNC_RUN: begin
               if (tok_in.fired < FIRE_CAP && taken_ff && enabled_ff &&
                   elapsed >= period_ff) begin
                  start_in          = tok_in.now;
                  tok_in_next.fired = tok_in.fired + 4'd1;
                  hit.valid         = 1'b1;
                  hit.status        = STATUS_FIRED;
                  hit.index         = cell_index;
                  hit.tag           = tag_ff;
                  if (one_shot_ff) begin
                     taken_in    = 1'b0;
                     enabled_in  = 1'b0;
                     one_shot_in = 1'b0;
                  end
               end
            end
            FUNC_ENABLE: begin
               if (mine) begin
                  enabled_in = 1'b1;
                  start_in   = tok_in.now;
               end
            end
            FUNC_DISABLE: begin
               if (mine) begin
                  enabled_in = 1'b0;
               end
            end
            FUNC_DELETE: begin
               // payload fields are dead while the slot is not taken
               if (mine) begin
                  taken_in    = 1'b0;
                  enabled_in  = 1'b0;
                  one_shot_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff    <= 1'b0;
         enabled_ff  <= 1'b0;
         one_shot_ff <= 1'b0;
         tok_ff      <= '0;
      end else begin
         taken_ff    <= taken_in;
         enabled_ff  <= enabled_in;
         one_shot_ff <= one_shot_in;
         tok_ff      <= tok_in_next;
      end
   end

   always_ff @(posedge clock) begin
      period_ff <= period_in;
      start_ff  <= start_in;
      tag_ff    <= tag_in;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

### rtl/periodic_timer_slot_table.sv
// Top level: command intake, chain of slot cells and result sequencing.
//
//  channel  ports                                        transfer when
//  request  start, busy, req_func/now_ms/interval_ms/    start && !busy
//           req_task_tag/req_slot
//  result   rsp_valid, rsp_status/slot_index/            rsp_valid (one cycle)
//           fired_tag/last
//
// A chain command is registered into the launch token, then steps through one
// slot cell per cycle, and the final result is registered. An ignored command
// answers the next cycle and leaves busy low. Each fired slot is held in a
// pending register until the next hit or the end of the chain, so that the
// last one can carry rsp_last. Synchronous reset frees every slot. Results
// cannot be stalled; busy is the only back pressure.
`default_nettype none
module periodic_timer_slot_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [31:0] req_interval_ms,
   input  wire logic [15:0] req_task_tag,
   input  wire logic [3:0]  req_slot,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_slot_index,
   output logic [15:0]      rsp_fired_tag,
   output logic             rsp_last
);
   import ptst_pkg::*;

   token_type  tok [SLOT_COUNT+1];
   hit_type    hits [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] hit_vec;
   hit_type    hit_any;
   token_type  tok_end;
   token_type  launch_ff, launch_in;
   hit_type    pend_ff, pend_in;
   logic       busy_ff, busy_in;
   logic       accept;
   logic       ignored;
   logic [2:0] end_status;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_slot_index_ff, rsp_slot_index_in;
   logic [15:0] rsp_fired_tag_ff, rsp_fired_tag_in;
   logic        rsp_last_ff, rsp_last_in;

   assign accept = start && !busy_ff;
   assign ignored = (req_func > FUNC_DELETE) ||
                    (req_func >= FUNC_ENABLE && {1'b0, req_slot} >= SLOT_LIMIT);

   assign tok[0] = launch_ff;
   assign tok_end = tok[SLOT_COUNT];

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      ptst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (4'(i)),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .hit        (hits[i])
      );
      assign hit_vec[i] = hits[i].valid;
   end

   // only the cell holding the token can raise a hit
   always_comb begin
      hit_any = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         hit_any = hit_any | hits[i];
      end
   end

   always_comb begin
      unique case (tok_end.func)
         FUNC_REG_PERIODIC, FUNC_REG_ONE_SHOT: end_status = STATUS_FULL;
         FUNC_RUN:                             end_status = STATUS_NONE;
         default:                              end_status = STATUS_OK;
      endcase
   end

   always_comb begin
      busy_in           = busy_ff;
      launch_in         = launch_ff;
      launch_in.valid   = 1'b0;
      pend_in           = pend_ff;
      rsp_valid_in      = 1'b0;
      rsp_status_in     = rsp_status_ff;
      rsp_slot_index_in = rsp_slot_index_ff;
      rsp_fired_tag_in  = rsp_fired_tag_ff;
      rsp_last_in       = rsp_last_ff;
      if (accept) begin
         if (ignored) begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = STATUS_IGNORED;
            rsp_slot_index_in = '0;
            rsp_fired_tag_in  = '0;
            rsp_last_in       = 1'b1;
         end else begin
            busy_in   = 1'b1;
            launch_in = '{valid: 1'b1, func: req_func, now: req_now_ms,
                          period: req_interval_ms, tag: req_task_tag,
                          slot: req_slot, claimed: 1'b0, fired: 4'd0};
         end
      end
      if (hit_any.valid) begin
         if (pend_ff.valid) begin
            rsp_valid_in      = 1'b1;
            rsp_status_in     = pend_ff.status;
            rsp_slot_index_in = pend_ff.index;
            rsp_fired_tag_in  = pend_ff.tag;
            rsp_last_in       = 1'b0;
         end
         pend_in = hit_any;
      end
      if (tok_end.valid) begin
         busy_in       = 1'b0;
         pend_in.valid = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_last_in   = 1'b1;
         if (pend_ff.valid) begin
            rsp_status_in     = pend_ff.status;
            rsp_slot_index_in = pend_ff.index;
            rsp_fired_tag_in  = pend_ff.tag;
         end else begin
            rsp_status_in     = end_status;
            rsp_slot_index_in = '0;
            rsp_fired_tag_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff           <= 1'b0;
         launch_ff         <= '0;
         pend_ff           <= '0;
         rsp_valid_ff      <= 1'b0;
         rsp_status_ff     <= '0;
         rsp_slot_index_ff <= '0;
         rsp_fired_tag_ff  <= '0;
         rsp_last_ff       <= 1'b0;
      end else begin
         busy_ff           <= busy_in;
         launch_ff         <= launch_in;
         pend_ff           <= pend_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_status_ff     <= rsp_status_in;
         rsp_slot_index_ff <= rsp_slot_index_in;
         rsp_fired_tag_ff  <= rsp_fired_tag_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_index_ff;
   assign rsp_fired_tag  = rsp_fired_tag_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one slot cell raised a hit");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("final result while still busy");

   a_ignored: assert property (@(posedge clock) disable iff (reset)
      accept && ignored |=> rsp_valid && rsp_last && rsp_status == STATUS_IGNORED)
      else $error("ignored command not answered next cycle");

   a_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FIRED |-> rsp_fired_tag == 16'd0)
      else $error("tag reported on a result that did not fire");
`endif

endmodule
`default_nettype wire
